// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files that carry checks.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/rc4_pkg.sv =====
`default_nettype none

package rc4_pkg;

  localparam int KEY_BYTES_MAX_DEF = 256;
  localparam int BYTE_W = 8;
  localparam int SBOX_DEPTH = 256;
  localparam logic [BYTE_W-1:0] SBOX_LAST = 8'hff;

  localparam logic FUNC_KEY = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] byte_in;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic              last_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_D_RJ,
    ST_D_WI,
    ST_D_OUT,
    ST_K_RN,
    ST_K_RJ,
    ST_K_WN,
    ST_K_WJ
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_KEY,
    OP_KEY_LAST,
    OP_DATA_ACCEPT,
    OP_D_READ_J,
    OP_D_WRITE_I,
    OP_D_FINISH,
    OP_K_READ_N,
    OP_K_READ_J,
    OP_K_WRITE_N,
    OP_K_WRITE_J
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sched_last;
    logic out_blocked;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rc4_ram.sv =====
`default_nettype none

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rc4_ctrl.sv =====
`default_nettype none

module rc4_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  rc4_pkg::in_item_t    in_data,
  output logic                 in_stall,
  output rc4_pkg::ctrl_cmd_t   cmd,
  input  rc4_pkg::dp_status_t  status
);
  import rc4_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.func == FUNC_DATA) begin
            state_nxt = ST_D_RJ;
          end else if (in_data.last) begin
            state_nxt = ST_K_RN;
          end
        end
      end
      ST_D_RJ:  state_nxt = ST_D_WI;
      ST_D_WI:  state_nxt = ST_D_OUT;
      ST_D_OUT: begin
        if (!status.out_blocked) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_K_RN:  state_nxt = ST_K_RJ;
      ST_K_RJ:  state_nxt = ST_K_WN;
      ST_K_WN:  state_nxt = ST_K_WJ;
      ST_K_WJ:  state_nxt = status.sched_last ? ST_IDLE : ST_K_RN;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd.op   = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_data.func == FUNC_DATA) begin
            cmd.op = OP_DATA_ACCEPT;
          end else if (in_data.last) begin
            cmd.op = OP_KEY_LAST;
          end else begin
            cmd.op = OP_KEY;
          end
        end
      end
      ST_D_RJ:  cmd.op = OP_D_READ_J;
      ST_D_WI:  cmd.op = OP_D_WRITE_I;
      ST_D_OUT: cmd.op = OP_D_FINISH;
      ST_K_RN:  cmd.op = OP_K_READ_N;
      ST_K_RJ:  cmd.op = OP_K_READ_J;
      ST_K_WN:  cmd.op = OP_K_WRITE_N;
      ST_K_WJ:  cmd.op = OP_K_WRITE_J;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rc4_dp.sv =====
`default_nettype none

module rc4_dp #(
  parameter int KEY_BYTES_MAX = rc4_pkg::KEY_BYTES_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rc4_pkg::ctrl_cmd_t   cmd,
  output rc4_pkg::dp_status_t  status,
  input  rc4_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rc4_pkg::out_item_t   out_data
);
  import rc4_pkg::*;

  localparam int KW  = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
  localparam int FW  = $clog2(KEY_BYTES_MAX + 1);
  localparam int FW1 = FW + 1;

  logic [BYTE_W-1:0]     i_r, i_nxt;
  logic [BYTE_W-1:0]     j_r, j_nxt;
  logic [BYTE_W-1:0]     n_r, n_nxt;
  logic [BYTE_W-1:0]     si_r, si_nxt;
  logic [BYTE_W-1:0]     sj_r, sj_nxt;
  logic [BYTE_W-1:0]     t_r, t_nxt;
  logic [BYTE_W-1:0]     byte_r, byte_nxt;
  logic                  last_r, last_nxt;
  logic [FW-1:0]         fill_r, fill_nxt;
  logic [FW-1:0]         klen_r, klen_nxt;
  logic [KW-1:0]         kpos_r, kpos_nxt;
  logic [SBOX_DEPTH-1:0] vld_r, vld_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [BYTE_W-1:0]     rd_addr_r, rd_addr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  p_we;
  logic [BYTE_W-1:0]     p_waddr;
  logic [BYTE_W-1:0]     p_wdata;
  logic                  p_re;
  logic [BYTE_W-1:0]     p_raddr;
  logic [BYTE_W-1:0]     p_q_raw;
  logic [BYTE_W-1:0]     perm_q;

  logic                  k_we;
  logic                  k_re;
  logic [KW-1:0]         k_raddr;
  logic [BYTE_W-1:0]     k_q;

  logic                  key_room;
  logic [FW-1:0]         fill_inc;
  logic [FW-1:0]         klen_eff;
  logic [FW1-1:0]        kpos_plus;
  logic [BYTE_W-1:0]     ks;
  logic                  out_blocked;

  // Entries not written since the last key schedule read as the identity permutation.
  assign perm_q = rd_vld_r ? p_q_raw : rd_addr_r;

  assign key_room    = (fill_r < FW'(KEY_BYTES_MAX));
  assign fill_inc    = key_room ? FW'(fill_r + 1'b1) : fill_r;
  assign klen_eff    = (klen_r == '0) ? FW'(1) : klen_r;
  assign kpos_plus   = FW1'(kpos_r) + FW1'(1);
  assign out_blocked = out_valid_r & out_stall;

  assign ks = (t_r == i_r) ? sj_r : ((t_r == j_r) ? si_r : perm_q);

  always_comb begin
    i_nxt        = i_r;
    j_nxt        = j_r;
    n_nxt        = n_r;
    si_nxt       = si_r;
    sj_nxt       = sj_r;
    t_nxt        = t_r;
    byte_nxt     = byte_r;
    last_nxt     = last_r;
    fill_nxt     = fill_r;
    klen_nxt     = klen_r;
    kpos_nxt     = kpos_r;
    vld_nxt      = vld_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r & out_stall;
    p_we    = 1'b0;
    p_waddr = '0;
    p_wdata = '0;
    p_re    = 1'b0;
    p_raddr = '0;
    k_we    = 1'b0;
    k_re    = 1'b0;
    k_raddr = '0;
    case (cmd.op)
      OP_KEY: begin
        k_we     = key_room;
        fill_nxt = fill_inc;
      end
      OP_KEY_LAST: begin
        k_we     = key_room;
        klen_nxt = fill_inc;
        fill_nxt = '0;
        vld_nxt  = '0;
        i_nxt    = '0;
        j_nxt    = '0;
        n_nxt    = '0;
        kpos_nxt = '0;
      end
      OP_DATA_ACCEPT: begin
        i_nxt    = i_r + 1'b1;
        p_re     = 1'b1;
        p_raddr  = i_nxt;
        byte_nxt = in_data.byte_in;
        last_nxt = in_data.last;
      end
      OP_D_READ_J: begin
        si_nxt  = perm_q;
        j_nxt   = j_r + perm_q;
        p_re    = 1'b1;
        p_raddr = j_nxt;
      end
      OP_D_WRITE_I: begin
        sj_nxt  = perm_q;
        p_we    = 1'b1;
        p_waddr = i_r;
        p_wdata = perm_q;
        t_nxt   = si_r + perm_q;
        p_re    = 1'b1;
        p_raddr = t_nxt;
      end
      OP_D_FINISH: begin
        p_we    = 1'b1;
        p_waddr = j_r;
        p_wdata = si_r;
        if (!out_blocked) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.byte_out = byte_r ^ ks;
          out_data_nxt.last_out = last_r;
        end
      end
      OP_K_READ_N: begin
        p_re    = 1'b1;
        p_raddr = n_r;
        k_re    = 1'b1;
        k_raddr = kpos_r;
      end
      OP_K_READ_J: begin
        si_nxt  = perm_q;
        j_nxt   = j_r + perm_q + k_q;
        p_re    = 1'b1;
        p_raddr = j_nxt;
      end
      OP_K_WRITE_N: begin
        p_we    = 1'b1;
        p_waddr = n_r;
        p_wdata = perm_q;
      end
      OP_K_WRITE_J: begin
        p_we    = 1'b1;
        p_waddr = j_r;
        p_wdata = si_r;
        n_nxt   = n_r + 1'b1;
        if (kpos_plus >= FW1'(klen_eff)) begin
          kpos_nxt = '0;
        end else begin
          kpos_nxt = kpos_r + 1'b1;
        end
        if (n_r == SBOX_LAST) begin
          j_nxt = '0;
        end
      end
      default: begin
      end
    endcase
    if (p_we) begin
      vld_nxt[p_waddr] = 1'b1;
    end
  end

  always_comb begin
    rd_vld_nxt  = rd_vld_r;
    rd_addr_nxt = rd_addr_r;
    if (p_re) begin
      rd_vld_nxt  = vld_r[p_raddr];
      rd_addr_nxt = p_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r         <= '0;
      j_r         <= '0;
      fill_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      fill_r      <= fill_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    t_r        <= t_nxt;
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    klen_r     <= klen_nxt;
    kpos_r     <= kpos_nxt;
    rd_vld_r   <= rd_vld_nxt;
    rd_addr_r  <= rd_addr_nxt;
    out_data_r <= out_data_nxt;
  end

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SBOX_DEPTH)
  ) u_perm_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_q_raw)
  );

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (KEY_BYTES_MAX)
  ) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (fill_r[KW-1:0]),
    .wdata (in_data.byte_in),
    .re    (k_re),
    .raddr (k_raddr),
    .rdata (k_q)
  );

  assign status.sched_last  = (n_r == SBOX_LAST);
  assign status.out_blocked = out_blocked;
  assign out_valid          = out_valid_r;
  assign out_data           = out_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rc4_stream_cipher.sv =====
// Channel  Direction  Payload                        Handshake
// in_      input      func, byte_in, last            in_valid / in_stall
// out_     output     byte_out, last_out             out_valid / out_stall
//
// A data beat is accepted in ST_IDLE, then takes three dependent steps, as the permutation
// memory has one read port: read S[j], swap write with read S[t], final write.
// A key beat is taken in ST_IDLE; the final key beat starts the key schedule, which steps
// through states ST_K_RN, ST_K_RJ, ST_K_WN, ST_K_WJ per S-box entry, with in_stall high.
// Reset is synchronous and active low; the permutation reads as identity without a sweep.
// A data beat may be accepted while the previous result still waits under out_stall.
`default_nettype none
`include "assert_macros.svh"

module rc4_stream_cipher #(
  parameter int KEY_BYTES_MAX = rc4_pkg::KEY_BYTES_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rc4_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rc4_pkg::out_item_t out_data
);
  import rc4_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  rc4_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  rc4_dp #(
    .KEY_BYTES_MAX (KEY_BYTES_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `ASSERT_NEXT(a_data_busy, in_valid && !in_stall && (in_data.func == FUNC_DATA), in_stall)
  `ASSERT_NEXT(a_finish_out, (cmd.op == OP_D_FINISH) && !status.out_blocked, out_valid)
  `ASSERT_NEXT(a_sched_start, cmd.op == OP_KEY_LAST, cmd.op == OP_K_READ_N)

endmodule

`default_nettype wire
